// ===== rtl/maxrects_rectangle_packer_core_defines.svh =====
// Assertion macros for the checker module.
`ifndef MAXRECTS_RECTANGLE_PACKER_CORE_DEFINES_SVH
`define MAXRECTS_RECTANGLE_PACKER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset
`define MRP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset
`define MRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mrp_pkg.sv =====
package mrp_pkg;

    localparam int DIM_W     = 13;
    localparam int POS_W     = 12;
    localparam int AREA_W    = 25;
    localparam int RAREA_W   = 26;
    localparam int SCORE_W   = 27;
    localparam int STAT_W    = 2;
    localparam int HEUR_W    = 3;
    localparam int CFG_IDX_W = 2;

    // Request operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_RESET  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BIN_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_H = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEUR  = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        STAT_PLACED = 2'd0,
        STAT_NOFIT  = 2'd1,
        STAT_FULL   = 2'd2
    } status_t;

    typedef enum logic [HEUR_W-1:0] {
        HEUR_SHORT   = 3'd0,
        HEUR_AREA    = 3'd1,
        HEUR_LONG    = 3'd2,
        HEUR_BL      = 3'd3,
        HEUR_CONTACT = 3'd4
    } heur_t;

    typedef struct packed {
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } box_t;

    // Free list entry: dead marks an entry pruned but not yet compacted out
    typedef struct packed {
        logic dead;
        box_t box;
    } fent_t;

    typedef struct packed {
        heur_t              mode;
        box_t               cand;
        logic [DIM_W-1:0]   rw;
        logic [DIM_W-1:0]   rh;
        logic [RAREA_W-1:0] rarea;
        logic [SCORE_W-1:0] contact;
    } score_in_t;

    typedef struct packed {
        logic [SCORE_W-1:0] s1;
        logic [DIM_W-1:0]   s2;
    } score_t;

    function automatic logic [DIM_W:0] box_right(input box_t b);
        return {1'b0, b.x} + {1'b0, b.w};
    endfunction

    function automatic logic [DIM_W:0] box_bottom(input box_t b);
        return {1'b0, b.y} + {1'b0, b.h};
    endfunction

    // a lies within b
    function automatic logic box_inside(input box_t a, input box_t b);
        return (a.x >= b.x) && (a.y >= b.y) &&
               (box_right(a) <= box_right(b)) && (box_bottom(a) <= box_bottom(b));
    endfunction

    // Length of the overlap of two spans
    function automatic logic [DIM_W:0] span_overlap(input logic [DIM_W:0] a0,
                                                    input logic [DIM_W:0] a1,
                                                    input logic [DIM_W:0] b0,
                                                    input logic [DIM_W:0] b1);
        logic [DIM_W:0] s;
        logic [DIM_W:0] e;
        s = (a0 > b0) ? a0 : b0;
        e = (a1 < b1) ? a1 : b1;
        return (e > s) ? (e - s) : '0;
    endfunction

endpackage

// ===== rtl/mrp_score.sv =====
module mrp_score (
    input  logic               aclk,
    input  mrp_pkg::score_in_t sin,
    output mrp_pkg::score_t    sout
);
    import mrp_pkg::*;

    logic [DIM_W-1:0]   lh;
    logic [DIM_W-1:0]   lv;
    logic [DIM_W-1:0]   short_s;
    logic [DIM_W-1:0]   long_s;
    logic [RAREA_W-1:0] farea;
    score_t             score_reg;
    score_t             score_next;

    // Leftovers and the candidate score under the selected heuristic
    always_comb begin
        lh      = sin.cand.w - sin.rw;
        lv      = sin.cand.h - sin.rh;
        short_s = (lh < lv) ? lh : lv;
        long_s  = (lh < lv) ? lv : lh;
        farea   = RAREA_W'(sin.cand.w) * RAREA_W'(sin.cand.h);
        case (sin.mode)
            HEUR_AREA: begin
                score_next.s1 = SCORE_W'(farea - sin.rarea);
                score_next.s2 = short_s;
            end
            HEUR_LONG: begin
                score_next.s1 = SCORE_W'(long_s);
                score_next.s2 = short_s;
            end
            HEUR_BL: begin
                score_next.s1 = SCORE_W'(sin.cand.y);
                score_next.s2 = sin.cand.x;
            end
            HEUR_CONTACT: begin
                score_next.s1 = sin.contact;
                score_next.s2 = '0;
            end
            default: begin
                score_next.s1 = SCORE_W'(short_s);
                score_next.s2 = long_s;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        score_reg <= score_next;
    end

    assign sout = score_reg;

endmodule

// ===== rtl/maxrects_rectangle_packer_core.sv =====
// Insert: search the free list, scoring each fitting entry (under contact point, after a pass over
// the used list), split the hit entries into pieces, append the pieces, prune contained entries,
// compact, then commit. One request at a time, bounded by the single read port of the free list
// memory. Reset request: reload the whole bin in ST_REFILL, then answer.
// aresetn (synchronous, active low) restores the control registers and loads the whole bin into
// free entry zero in ST_INIT before the first request is taken.
module maxrects_rectangle_packer_core #(
    parameter int MAX_FREE = 256,
    parameter int MAX_USED = 256,
    parameter int MAX_DIM  = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [mrp_pkg::DIM_W-1:0]     s_rect_width,
    input  logic [mrp_pkg::DIM_W-1:0]     s_rect_height,
    input  logic                          cfg_wr_en,
    input  logic [mrp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mrp_pkg::DIM_W-1:0]     cfg_wdata,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mrp_pkg::STAT_W-1:0]    m_status,
    output logic [mrp_pkg::POS_W-1:0]     m_pos_x,
    output logic [mrp_pkg::POS_W-1:0]     m_pos_y,
    output logic                          m_free_overflow,
    output logic [mrp_pkg::AREA_W-1:0]    m_used_area
);
    import mrp_pkg::*;

    localparam int AW        = $clog2(MAX_FREE);
    localparam int CW        = $clog2(MAX_FREE + 1);
    localparam int UAW       = $clog2(MAX_USED);
    localparam int UCW       = $clog2(MAX_USED + 1);
    localparam int MAX_DIM_C = (MAX_DIM > 8191) ? 8191 : MAX_DIM;
    localparam logic [DIM_W-1:0]  DIM_LIM  = DIM_W'(MAX_DIM_C);
    localparam logic [AREA_W-1:0] AREA_MAX = '1;

    typedef enum logic [20:0] {
        ST_INIT     = 21'h000001,
        ST_IDLE     = 21'h000002,
        ST_REFILL   = 21'h000004,
        ST_FIND_RD  = 21'h000008,
        ST_FIND_EV  = 21'h000010,
        ST_CT_RD    = 21'h000020,
        ST_CT_EV    = 21'h000040,
        ST_SCORE    = 21'h000080,
        ST_FIND_CMP = 21'h000100,
        ST_SPL_RD   = 21'h000200,
        ST_SPL_EV   = 21'h000400,
        ST_SPL_PC   = 21'h000800,
        ST_CPY_RD   = 21'h001000,
        ST_CPY_WR   = 21'h002000,
        ST_PR_I_RD  = 21'h004000,
        ST_PR_I_EV  = 21'h008000,
        ST_PR_J_RD  = 21'h010000,
        ST_PR_J_EV  = 21'h020000,
        ST_CMP_RD   = 21'h040000,
        ST_CMP_WR   = 21'h080000,
        ST_COMMIT   = 21'h100000
    } state_t;

    // Control registers
    state_t               state_reg, state_next;
    logic [DIM_W-1:0]     bin_w_reg, bin_h_reg;
    logic [HEUR_W-1:0]    heur_reg;
    logic [CW-1:0]        free_cnt_reg, free_cnt_next;
    logic [UCW-1:0]       used_cnt_reg, used_cnt_next;
    logic [AREA_W-1:0]    area_reg, area_next;
    logic                 m_valid_reg, m_valid_next;

    // Working registers
    heur_t                mode_reg, mode_next;
    logic [DIM_W-1:0]     rw_reg, rw_next, rh_reg, rh_next;
    logic [RAREA_W-1:0]   rarea_reg, rarea_next;
    logic [CW-1:0]        ra_reg, ra_next, wa_reg, wa_next, pj_reg, pj_next;
    logic [CW-1:0]        cur_cnt_reg, cur_cnt_next, pc_cnt_reg, pc_cnt_next;
    logic [1:0]           piece_reg, piece_next;
    box_t                 cur_reg, cur_next, ia_reg, ia_next;
    logic                 found_reg, found_next;
    logic [SCORE_W-1:0]   best_s1_reg, best_s1_next;
    logic [DIM_W-1:0]     best_s2_reg, best_s2_next;
    logic [DIM_W-1:0]     best_x_reg, best_x_next, best_y_reg, best_y_next;
    logic [DIM_W-1:0]     px_reg, px_next, py_reg, py_next;
    logic [SCORE_W-1:0]   ct_acc_reg, ct_acc_next;
    logic [UCW-1:0]       uj_reg, uj_next;
    logic                 spill_reg, spill_next;
    status_t              status_reg, status_next;

    // Memories
    fent_t                fa_mem [MAX_FREE];
    fent_t                fa_rdata, fa_wdata;
    logic [AW-1:0]        fa_raddr, fa_waddr;
    logic                 fa_we;
    fent_t                pc_mem [MAX_FREE];
    fent_t                pc_rdata, pc_wdata;
    logic [AW-1:0]        pc_raddr, pc_waddr;
    logic                 pc_we;
    box_t                 u_mem [MAX_USED];
    box_t                 u_rdata, u_wdata;
    logic [UAW-1:0]       u_raddr, u_waddr;
    logic                 u_we;

    // Datapath
    logic [DIM_W-1:0]     eff_w, eff_h;
    logic                 s_fire;
    logic                 fits;
    logic [SCORE_W-1:0]   edge_ct;
    logic [DIM_W:0]       ul, ur, ut, ub, fl, fr, ft, fb;
    logic                 hit;
    logic                 pv;
    box_t                 pbox;
    logic [DIM_W:0]       cxr, cyb, t1, t2;
    logic                 better;
    logic [SCORE_W-1:0]   area_sum;
    score_in_t            sc_in;
    score_t               sc_out;

    assign eff_w   = (bin_w_reg > DIM_LIM) ? DIM_LIM : bin_w_reg;
    assign eff_h   = (bin_h_reg > DIM_LIM) ? DIM_LIM : bin_h_reg;
    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign s_fire  = s_valid && s_ready;

    // Shared scoring stage
    assign sc_in = '{mode: mode_reg, cand: cur_reg, rw: rw_reg, rh: rh_reg,
                     rarea: rarea_reg, contact: ct_acc_reg};

    mrp_score u_score (
        .aclk (aclk),
        .sin  (sc_in),
        .sout (sc_out)
    );

    // Fit test and bin edge contact for the entry just read
    assign fits = (fa_rdata.box.w >= rw_reg) && (fa_rdata.box.h >= rh_reg);
    assign edge_ct =
        (((fa_rdata.box.x == '0) ||
          (({1'b0, fa_rdata.box.x} + {1'b0, rw_reg}) == {1'b0, eff_w}))
            ? SCORE_W'(rh_reg) : '0) +
        (((fa_rdata.box.y == '0) ||
          (({1'b0, fa_rdata.box.y} + {1'b0, rh_reg}) == {1'b0, eff_h}))
            ? SCORE_W'(rw_reg) : '0);

    // Contact with one placed rectangle
    assign cxr = {1'b0, cur_reg.x} + {1'b0, rw_reg};
    assign cyb = {1'b0, cur_reg.y} + {1'b0, rh_reg};
    assign t1  = (({1'b0, u_rdata.x} == cxr) || (box_right(u_rdata) == {1'b0, cur_reg.x}))
                 ? span_overlap({1'b0, u_rdata.y}, box_bottom(u_rdata),
                                {1'b0, cur_reg.y}, cyb) : '0;
    assign t2  = (({1'b0, u_rdata.y} == cyb) || (box_bottom(u_rdata) == {1'b0, cur_reg.y}))
                 ? span_overlap({1'b0, u_rdata.x}, box_right(u_rdata),
                                {1'b0, cur_reg.x}, cxr) : '0;

    assign better = !found_reg ||
                    ((mode_reg == HEUR_CONTACT) ? (sc_out.s1 > best_s1_reg)
                     : ((sc_out.s1 < best_s1_reg) ||
                        ((sc_out.s1 == best_s1_reg) && (sc_out.s2 < best_s2_reg))));

    // Placed rectangle bounds and the free entry under split
    assign ul  = {1'b0, best_x_reg};
    assign ur  = {1'b0, best_x_reg} + {1'b0, rw_reg};
    assign ut  = {1'b0, best_y_reg};
    assign ub  = {1'b0, best_y_reg} + {1'b0, rh_reg};
    assign hit = !((ul >= box_right(fa_rdata.box)) || (ur <= {1'b0, fa_rdata.box.x}) ||
                   (ut >= box_bottom(fa_rdata.box)) || (ub <= {1'b0, fa_rdata.box.y}));
    assign fl  = {1'b0, cur_reg.x};
    assign fr  = box_right(cur_reg);
    assign ft  = {1'b0, cur_reg.y};
    assign fb  = box_bottom(cur_reg);

    // Split pieces: top, bottom, left, right
    always_comb begin
        case (piece_reg)
            2'd0: begin
                pv   = (ut > ft) && (ut < fb);
                pbox = '{x: cur_reg.x, y: cur_reg.y, w: cur_reg.w, h: DIM_W'(ut - ft)};
            end
            2'd1: begin
                pv   = (ub < fb) && (ub > ft);
                pbox = '{x: cur_reg.x, y: DIM_W'(ub), w: cur_reg.w, h: DIM_W'(fb - ub)};
            end
            2'd2: begin
                pv   = (ul > fl) && (ul < fr);
                pbox = '{x: cur_reg.x, y: cur_reg.y, w: DIM_W'(ul - fl), h: cur_reg.h};
            end
            default: begin
                pv   = (ur < fr) && (ur > fl);
                pbox = '{x: DIM_W'(ur), y: cur_reg.y, w: DIM_W'(fr - ur), h: cur_reg.h};
            end
        endcase
    end

    assign area_sum = {2'b00, area_reg} + {1'b0, rarea_reg};

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        free_cnt_next = free_cnt_reg;
        used_cnt_next = used_cnt_reg;
        area_next     = area_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        mode_next     = mode_reg;
        rw_next       = rw_reg;
        rh_next       = rh_reg;
        rarea_next    = rarea_reg;
        ra_next       = ra_reg;
        wa_next       = wa_reg;
        pj_next       = pj_reg;
        cur_cnt_next  = cur_cnt_reg;
        pc_cnt_next   = pc_cnt_reg;
        piece_next    = piece_reg;
        cur_next      = cur_reg;
        ia_next       = ia_reg;
        found_next    = found_reg;
        best_s1_next  = best_s1_reg;
        best_s2_next  = best_s2_reg;
        best_x_next   = best_x_reg;
        best_y_next   = best_y_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        ct_acc_next   = ct_acc_reg;
        uj_next       = uj_reg;
        spill_next    = spill_reg;
        status_next   = status_reg;
        fa_we         = 1'b0;
        fa_waddr      = wa_reg[AW-1:0];
        fa_wdata      = '{dead: 1'b0, box: fa_rdata.box};
        fa_raddr      = (state_reg == ST_PR_J_RD) ? pj_reg[AW-1:0] : ra_reg[AW-1:0];
        pc_we         = 1'b0;
        pc_waddr      = pc_cnt_reg[AW-1:0];
        pc_wdata      = '{dead: 1'b0, box: pbox};
        pc_raddr      = pj_reg[AW-1:0];
        u_we          = 1'b0;
        u_waddr       = used_cnt_reg[UAW-1:0];
        u_wdata       = '{x: best_x_reg, y: best_y_reg, w: rw_reg, h: rh_reg};
        u_raddr       = uj_reg[UAW-1:0];

        case (state_reg)
            // Load the whole bin as the only free entry
            ST_INIT, ST_REFILL: begin
                fa_we         = 1'b1;
                fa_waddr      = '0;
                fa_wdata      = '{dead: 1'b0, box: '{x: '0, y: '0, w: eff_w, h: eff_h}};
                free_cnt_next = ((eff_w != '0) && (eff_h != '0)) ? CW'(1) : '0;
                used_cnt_next = '0;
                area_next     = '0;
                state_next    = ST_IDLE;
                if (state_reg == ST_REFILL) begin
                    m_valid_next = 1'b1;
                end
            end

            ST_IDLE: begin
                if (s_fire) begin
                    rw_next     = s_rect_width;
                    rh_next     = s_rect_height;
                    rarea_next  = RAREA_W'(s_rect_width) * RAREA_W'(s_rect_height);
                    mode_next   = (heur_reg > HEUR_W'(HEUR_CONTACT)) ? HEUR_SHORT
                                                                     : heur_t'(heur_reg);
                    px_next     = '0;
                    py_next     = '0;
                    spill_next  = 1'b0;
                    found_next  = 1'b0;
                    ra_next     = '0;
                    status_next = STAT_PLACED;
                    if (s_operation == OP_RESET) begin
                        state_next = ST_REFILL;
                    end else if (used_cnt_reg >= UCW'(MAX_USED)) begin
                        status_next  = STAT_FULL;
                        m_valid_next = 1'b1;
                    end else if ((s_rect_width == '0) || (s_rect_height == '0)) begin
                        status_next  = STAT_NOFIT;
                        m_valid_next = 1'b1;
                    end else begin
                        state_next = ST_FIND_RD;
                    end
                end
            end

            // Search the free list in order
            ST_FIND_RD: begin
                if (ra_reg == free_cnt_reg) begin
                    if (found_reg) begin
                        ra_next      = '0;
                        wa_next      = '0;
                        cur_cnt_next = free_cnt_reg;
                        pc_cnt_next  = '0;
                        state_next   = ST_SPL_RD;
                    end else begin
                        status_next  = STAT_NOFIT;
                        m_valid_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    state_next = ST_FIND_EV;
                end
            end

            ST_FIND_EV: begin
                cur_next = fa_rdata.box;
                if (!fits) begin
                    ra_next    = ra_reg + CW'(1);
                    state_next = ST_FIND_RD;
                end else if (mode_reg == HEUR_CONTACT) begin
                    ct_acc_next = edge_ct;
                    uj_next     = '0;
                    state_next  = ST_CT_RD;
                end else begin
                    state_next = ST_SCORE;
                end
            end

            // Contact with every placed rectangle
            ST_CT_RD: begin
                state_next = (uj_reg == used_cnt_reg) ? ST_SCORE : ST_CT_EV;
            end

            ST_CT_EV: begin
                ct_acc_next = ct_acc_reg + SCORE_W'(t1) + SCORE_W'(t2);
                uj_next     = uj_reg + UCW'(1);
                state_next  = ST_CT_RD;
            end

            ST_SCORE: begin
                state_next = ST_FIND_CMP;
            end

            ST_FIND_CMP: begin
                if (better) begin
                    found_next   = 1'b1;
                    best_s1_next = sc_out.s1;
                    best_s2_next = sc_out.s2;
                    best_x_next  = cur_reg.x;
                    best_y_next  = cur_reg.y;
                end
                ra_next    = ra_reg + CW'(1);
                state_next = ST_FIND_RD;
            end

            // Split: keep untouched entries in order, collect pieces aside
            ST_SPL_RD: begin
                if (ra_reg == free_cnt_reg) begin
                    pj_next    = '0;
                    state_next = ST_CPY_RD;
                end else begin
                    state_next = ST_SPL_EV;
                end
            end

            ST_SPL_EV: begin
                if (!hit) begin
                    fa_we      = 1'b1;
                    wa_next    = wa_reg + CW'(1);
                    ra_next    = ra_reg + CW'(1);
                    state_next = ST_SPL_RD;
                end else begin
                    cur_next     = fa_rdata.box;
                    cur_cnt_next = cur_cnt_reg - CW'(1);
                    piece_next   = '0;
                    state_next   = ST_SPL_PC;
                end
            end

            ST_SPL_PC: begin
                if (pv) begin
                    if (cur_cnt_reg >= CW'(MAX_FREE)) begin
                        spill_next = 1'b1;
                    end else begin
                        pc_we        = 1'b1;
                        pc_cnt_next  = pc_cnt_reg + CW'(1);
                        cur_cnt_next = cur_cnt_reg + CW'(1);
                    end
                end
                if (piece_reg == 2'd3) begin
                    ra_next    = ra_reg + CW'(1);
                    state_next = ST_SPL_RD;
                end else begin
                    piece_next = piece_reg + 2'd1;
                end
            end

            // Append the pieces after the kept entries
            ST_CPY_RD: begin
                if (pj_reg == pc_cnt_reg) begin
                    free_cnt_next = wa_reg;
                    ra_next       = '0;
                    state_next    = ST_PR_I_RD;
                end else begin
                    state_next = ST_CPY_WR;
                end
            end

            ST_CPY_WR: begin
                fa_we      = 1'b1;
                fa_wdata   = '{dead: 1'b0, box: pc_rdata.box};
                wa_next    = wa_reg + CW'(1);
                pj_next    = pj_reg + CW'(1);
                state_next = ST_CPY_RD;
            end

            // Prune contained entries by marking them dead
            ST_PR_I_RD: begin
                if (ra_reg == free_cnt_reg) begin
                    ra_next    = '0;
                    wa_next    = '0;
                    state_next = ST_CMP_RD;
                end else begin
                    state_next = ST_PR_I_EV;
                end
            end

            ST_PR_I_EV: begin
                if (fa_rdata.dead) begin
                    ra_next    = ra_reg + CW'(1);
                    state_next = ST_PR_I_RD;
                end else begin
                    ia_next    = fa_rdata.box;
                    pj_next    = ra_reg + CW'(1);
                    state_next = ST_PR_J_RD;
                end
            end

            ST_PR_J_RD: begin
                if (pj_reg == free_cnt_reg) begin
                    ra_next    = ra_reg + CW'(1);
                    state_next = ST_PR_I_RD;
                end else begin
                    state_next = ST_PR_J_EV;
                end
            end

            ST_PR_J_EV: begin
                if (fa_rdata.dead) begin
                    pj_next    = pj_reg + CW'(1);
                    state_next = ST_PR_J_RD;
                end else if (box_inside(ia_reg, fa_rdata.box)) begin
                    fa_we      = 1'b1;
                    fa_waddr   = ra_reg[AW-1:0];
                    fa_wdata   = '{dead: 1'b1, box: ia_reg};
                    ra_next    = ra_reg + CW'(1);
                    state_next = ST_PR_I_RD;
                end else if (box_inside(fa_rdata.box, ia_reg)) begin
                    fa_we      = 1'b1;
                    fa_waddr   = pj_reg[AW-1:0];
                    fa_wdata   = '{dead: 1'b1, box: fa_rdata.box};
                    pj_next    = pj_reg + CW'(1);
                    state_next = ST_PR_J_RD;
                end else begin
                    pj_next    = pj_reg + CW'(1);
                    state_next = ST_PR_J_RD;
                end
            end

            // Squeeze out dead entries, order kept
            ST_CMP_RD: begin
                if (ra_reg == free_cnt_reg) begin
                    free_cnt_next = wa_reg;
                    state_next    = ST_COMMIT;
                end else begin
                    state_next = ST_CMP_WR;
                end
            end

            ST_CMP_WR: begin
                if (!fa_rdata.dead) begin
                    fa_we   = 1'b1;
                    wa_next = wa_reg + CW'(1);
                end
                ra_next    = ra_reg + CW'(1);
                state_next = ST_CMP_RD;
            end

            // Record the placement and answer
            ST_COMMIT: begin
                u_we          = 1'b1;
                used_cnt_next = used_cnt_reg + UCW'(1);
                area_next     = (area_sum > SCORE_W'(AREA_MAX)) ? AREA_MAX
                                                                : area_sum[AREA_W-1:0];
                px_next       = best_x_reg;
                py_next       = best_y_reg;
                status_next   = STAT_PLACED;
                m_valid_next  = 1'b1;
                state_next    = ST_IDLE;
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            bin_w_reg    <= DIM_W'(1024);
            bin_h_reg    <= DIM_W'(1024);
            heur_reg     <= HEUR_SHORT;
            free_cnt_reg <= '0;
            used_cnt_reg <= '0;
            area_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            free_cnt_reg <= free_cnt_next;
            used_cnt_reg <= used_cnt_next;
            area_reg     <= area_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_BIN_W: bin_w_reg <= cfg_wdata;
                    REG_BIN_H: bin_h_reg <= cfg_wdata;
                    REG_HEUR:  heur_reg  <= cfg_wdata[HEUR_W-1:0];
                    default:   ;
                endcase
            end
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        mode_reg    <= mode_next;
        rw_reg      <= rw_next;
        rh_reg      <= rh_next;
        rarea_reg   <= rarea_next;
        ra_reg      <= ra_next;
        wa_reg      <= wa_next;
        pj_reg      <= pj_next;
        cur_cnt_reg <= cur_cnt_next;
        pc_cnt_reg  <= pc_cnt_next;
        piece_reg   <= piece_next;
        cur_reg     <= cur_next;
        ia_reg      <= ia_next;
        found_reg   <= found_next;
        best_s1_reg <= best_s1_next;
        best_s2_reg <= best_s2_next;
        best_x_reg  <= best_x_next;
        best_y_reg  <= best_y_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        ct_acc_reg  <= ct_acc_next;
        uj_reg      <= uj_next;
        spill_reg   <= spill_next;
        status_reg  <= status_next;
    end

    // Free list memory
    always_ff @(posedge aclk) begin
        if (fa_we) begin
            fa_mem[fa_waddr] <= fa_wdata;
        end
        fa_rdata <= fa_mem[fa_raddr];
    end

    // Split piece buffer
    always_ff @(posedge aclk) begin
        if (pc_we) begin
            pc_mem[pc_waddr] <= pc_wdata;
        end
        pc_rdata <= pc_mem[pc_raddr];
    end

    // Used list memory
    always_ff @(posedge aclk) begin
        if (u_we) begin
            u_mem[u_waddr] <= u_wdata;
        end
        u_rdata <= u_mem[u_raddr];
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_pos_x         = px_reg[POS_W-1:0];
    assign m_pos_y         = py_reg[POS_W-1:0];
    assign m_free_overflow = spill_reg;
    assign m_used_area     = area_reg;

endmodule

// ===== rtl/mrp_checker.sv =====
`include "maxrects_rectangle_packer_core_defines.svh"

module mrp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          s_operation,
    input logic [mrp_pkg::DIM_W-1:0]     s_rect_width,
    input logic [mrp_pkg::DIM_W-1:0]     s_rect_height,
    input logic                          cfg_wr_en,
    input logic [mrp_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [mrp_pkg::DIM_W-1:0]     cfg_wdata,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [mrp_pkg::STAT_W-1:0]    m_status,
    input logic [mrp_pkg::POS_W-1:0]     m_pos_x,
    input logic [mrp_pkg::POS_W-1:0]     m_pos_y,
    input logic                          m_free_overflow,
    input logic [mrp_pkg::AREA_W-1:0]    m_used_area
);
    import mrp_pkg::*;

    // A stalled result holds
    `MRP_ASSERT_NEXT(a_res_hold, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_pos_x) && $stable(m_pos_y) && $stable(m_free_overflow) && $stable(m_used_area), "result changed while stalled")

    // Status is one of the defined codes
    `MRP_ASSERT_NOW(a_status_code, m_valid, (m_status == STAT_PLACED) || (m_status == STAT_NOFIT) || (m_status == STAT_FULL), "undefined status")

    // Only a placement reports a position or a dropped piece
    `MRP_ASSERT_NOW(a_unplaced_clean, m_valid && (m_status != STAT_PLACED), (m_pos_x == '0) && (m_pos_y == '0) && !m_free_overflow, "position or overflow on a rejected request")

    // One request in flight: no new request while a result waits
    `MRP_ASSERT_NOW(a_single_flight, s_ready, !m_valid, "ready while a result is pending")

endmodule

bind maxrects_rectangle_packer_core mrp_checker u_mrp_checker (.*);

// ===== tb/maxrects_rectangle_packer_core_tb.sv =====
module maxrects_rectangle_packer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mrp_pkg::*;

    localparam int FREE_DEPTH = 256;
    localparam int USED_DEPTH = 256;
    localparam int DIM_LIMIT  = 4096;
    localparam int AREA_SAT   = 32'h1FFFFFF;
    localparam int STALL_LIMIT = 300000;

    typedef struct {
        logic             op;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } rect_req_t;

    typedef struct {
        status_t           status;
        logic [POS_W-1:0]  px;
        logic [POS_W-1:0]  py;
        logic              ovf;
        logic [AREA_W-1:0] area;
    } placement_t;

    logic aclk;
    logic aresetn;
    logic s_valid, s_ready, s_operation;
    logic [DIM_W-1:0] s_rect_width, s_rect_height;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0] cfg_wdata;
    logic m_valid, m_ready;
    logic [STAT_W-1:0] m_status;
    logic [POS_W-1:0] m_pos_x, m_pos_y;
    logic m_free_overflow;
    logic [AREA_W-1:0] m_used_area;

    maxrects_rectangle_packer_core DUT (.*);

    // Packer shadow state
    box_t         spare_rects [FREE_DEPTH];
    int           spare_cnt;
    box_t         placed_rects [USED_DEPTH];
    int           placed_cnt;
    int unsigned  area_sum;
    logic         spilled;
    int unsigned  cfg_bw, cfg_bh, cfg_heur;

    rect_req_t  pending_reqs[$];
    placement_t expected_places[$];
    rect_req_t  cur_req;
    int err_count = 0;
    int send_idle = 0, recv_idle = 0;
    int unsigned stall_cycles = 0;

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    function automatic int unsigned clip_dim(int unsigned v);
        return v > DIM_LIMIT ? DIM_LIMIT : v;
    endfunction

    function automatic void empty_bin();
        int unsigned bw, bh;
        bw = clip_dim(cfg_bw);
        bh = clip_dim(cfg_bh);
        spare_cnt = 0;
        placed_cnt = 0;
        area_sum = 0;
        if (bw != 0 && bh != 0) begin
            spare_rects[0] = '{x: 0, y: 0, w: bw, h: bh};
            spare_cnt = 1;
        end
    endfunction

    function automatic void drop_spare(int k);
        for (int i = k; i < spare_cnt - 1; i++) spare_rects[i] = spare_rects[i+1];
        spare_cnt--;
    endfunction

    function automatic void add_spare(int unsigned x, int unsigned y,
                                      int unsigned w, int unsigned h);
        if (spare_cnt >= FREE_DEPTH) begin
            spilled = 1;
            return;
        end
        spare_rects[spare_cnt] = '{x: x, y: y, w: w, h: h};
        spare_cnt++;
    endfunction

    function automatic int unsigned span_len(int unsigned a0, int unsigned a1,
                                             int unsigned b0, int unsigned b1);
        int unsigned s, e;
        s = a0 > b0 ? a0 : b0;
        e = a1 < b1 ? a1 : b1;
        return e > s ? e - s : 0;
    endfunction

    function automatic int unsigned touch_score(int unsigned x, int unsigned y,
                                                int unsigned w, int unsigned h);
        int unsigned s, rx, ry, rw, rh;
        s = 0;
        if (x == 0 || x + w == clip_dim(cfg_bw)) s += h;
        if (y == 0 || y + h == clip_dim(cfg_bh)) s += w;
        for (int k = 0; k < placed_cnt; k++) begin
            rx = placed_rects[k].x; ry = placed_rects[k].y;
            rw = placed_rects[k].w; rh = placed_rects[k].h;
            if (rx == x + w || rx + rw == x) s += span_len(ry, ry + rh, y, y + h);
            if (ry == y + h || ry + rh == y) s += span_len(rx, rx + rw, x, x + w);
        end
        return s;
    endfunction

    // Pick the free entry by heuristic; first one wins on a tie
    function automatic int pick_spot(int unsigned w, int unsigned h);
        int best;
        int unsigned b1, b2, fw, fh, lh, lv, sh, lo, s1, s2, mode;
        logic better;
        best = -1; b1 = 0; b2 = 0;
        mode = cfg_heur > 4 ? 0 : cfg_heur;
        for (int k = 0; k < spare_cnt; k++) begin
            fw = spare_rects[k].w;
            fh = spare_rects[k].h;
            if (fw < w || fh < h) continue;
            lh = fw - w;
            lv = fh - h;
            sh = lh < lv ? lh : lv;
            lo = lh < lv ? lv : lh;
            case (mode)
                HEUR_AREA: begin s1 = fw * fh - w * h; s2 = sh; end
                HEUR_LONG: begin s1 = lo; s2 = sh; end
                HEUR_BL: begin s1 = spare_rects[k].y; s2 = spare_rects[k].x; end
                HEUR_CONTACT: begin
                    s1 = touch_score(spare_rects[k].x, spare_rects[k].y, w, h);
                    s2 = 0;
                end
                default: begin s1 = sh; s2 = lo; end
            endcase
            if (best < 0) better = 1;
            else if (mode == HEUR_CONTACT) better = s1 > b1;
            else better = s1 < b1 || (s1 == b1 && s2 < b2);
            if (better) begin
                best = k; b1 = s1; b2 = s2;
            end
        end
        return best;
    endfunction

    function automatic void carve_spares(int unsigned ul, int unsigned ut,
                                         int unsigned uw, int unsigned uh);
        int unsigned ur, ub, fl, fr, ft, fb, fw, fh;
        int n, k;
        ur = ul + uw; ub = ut + uh;
        n = spare_cnt; k = 0;
        while (k < n) begin
            fl = spare_rects[k].x; ft = spare_rects[k].y;
            fw = spare_rects[k].w; fh = spare_rects[k].h;
            fr = fl + fw; fb = ft + fh;
            if (ul >= fr || ur <= fl || ut >= fb || ub <= ft) begin
                k++;
                continue;
            end
            drop_spare(k);
            n--;
            if (ut > ft && ut < fb) add_spare(fl, ft, fw, ut - ft);
            if (ub < fb && ub > ft) add_spare(fl, ub, fw, fb - ub);
            if (ul > fl && ul < fr) add_spare(fl, ft, ul - fl, fh);
            if (ur < fr && ur > fl) add_spare(ur, ft, fr - ur, fh);
        end
    endfunction

    function automatic logic contained_in(box_t a, box_t b);
        return int'(a.x) >= int'(b.x) && int'(a.y) >= int'(b.y) &&
               int'(a.x) + int'(a.w) <= int'(b.x) + int'(b.w) &&
               int'(a.y) + int'(a.h) <= int'(b.y) + int'(b.h);
    endfunction

    function automatic void prune_spares();
        for (int i = 0; i < spare_cnt; i++) begin
            for (int j = i + 1; j < spare_cnt; j++) begin
                if (contained_in(spare_rects[i], spare_rects[j])) begin
                    drop_spare(i);
                    i--;
                    break;
                end
                if (contained_in(spare_rects[j], spare_rects[i])) begin
                    drop_spare(j);
                    j--;
                end
            end
        end
    endfunction

    function automatic placement_t place_rect(rect_req_t r);
        placement_t res;
        int k;
        int unsigned px, py;
        longint unsigned sum;
        res = '{status: STAT_PLACED, px: 0, py: 0, ovf: 0, area: 0};
        spilled = 0;
        if (r.op == OP_RESET) begin
            empty_bin();
        end else if (placed_cnt >= USED_DEPTH) begin
            res.status = STAT_FULL;
        end else begin
            k = (r.w == 0 || r.h == 0) ? -1 : pick_spot(r.w, r.h);
            if (k < 0) begin
                res.status = STAT_NOFIT;
            end else begin
                px = spare_rects[k].x;
                py = spare_rects[k].y;
                carve_spares(px, py, r.w, r.h);
                prune_spares();
                placed_rects[placed_cnt] = '{x: px, y: py, w: r.w, h: r.h};
                placed_cnt++;
                sum = longint'(area_sum) + longint'(r.w) * longint'(r.h);
                area_sum = sum > AREA_SAT ? AREA_SAT : sum;
                res.px = px;
                res.py = py;
            end
        end
        res.ovf = spilled;
        res.area = area_sum;
        return res;
    endfunction

    // Request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 0;
        end else begin
            if (s_valid && s_ready) expected_places.push_back(place_rect(cur_req));
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
                    cur_req = pending_reqs.pop_front();
                    s_valid <= 1;
                    s_operation <= cur_req.op;
                    s_rect_width <= cur_req.w;
                    s_rect_height <= cur_req.h;
                end else begin
                    s_valid <= 0;
                end
            end
        end
    end

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        err_count++;
    endtask

    // Result monitor
    always @(posedge aclk) begin
        placement_t e;
        if (!aresetn) begin
            m_ready <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_places.size() == 0) begin
                    report("unexpected result", m_status, -1);
                end else begin
                    e = expected_places.pop_front();
                    if (m_status !== e.status) report("status", m_status, e.status);
                    if (m_pos_x !== e.px) report("pos_x", m_pos_x, e.px);
                    if (m_pos_y !== e.py) report("pos_y", m_pos_y, e.py);
                    if (m_free_overflow !== e.ovf)
                        report("free_overflow", m_free_overflow, e.ovf);
                    if (m_used_area !== e.area) report("used_area", m_used_area, e.area);
                end
            end
            m_ready <= $urandom_range(99) >= recv_idle;
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
        @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 0;
        case (idx)
            REG_BIN_W: cfg_bw = v & 13'h1FFF;
            REG_BIN_H: cfg_bh = v & 13'h1FFF;
            default: cfg_heur = v & 3'h7;
        endcase
    endtask

    task automatic queue_req(logic op, int unsigned w, int unsigned h);
        rect_req_t r;
        r.op = op;
        r.w = w;
        r.h = h;
        pending_reqs.push_back(r);
    endtask

    // Sender holds off until the packer has drained
    task automatic drain();
        do @(negedge aclk);
        while (pending_reqs.size() > 0 || s_valid || expected_places.size() > 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic setup_bin(int unsigned bw, int unsigned bh, int unsigned heur);
        write_reg(REG_BIN_W, bw);
        write_reg(REG_BIN_H, bh);
        write_reg(REG_HEUR, heur);
        queue_req(OP_RESET, $urandom_range(8191), $urandom_range(8191));
    endtask

    task automatic random_run(int n, int unsigned bw, int unsigned bh);
        int unsigned p, mw, mh;
        mw = clip_dim(bw) / 2 + 1;
        mh = clip_dim(bh) / 2 + 1;
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(99);
            if (p < 85) queue_req(OP_INSERT, $urandom_range(mw, 1), $urandom_range(mh, 1));
            else if (p < 90) queue_req(OP_RESET, $urandom, $urandom);
            else queue_req(OP_INSERT, $urandom_range(8191), $urandom_range(8191));
        end
    endtask

    initial begin
        int unsigned bw, bh;
        aresetn = 0;
        s_valid = 0;
        s_operation = 0;
        s_rect_width = 0;
        s_rect_height = 0;
        cfg_wr_en = 0;
        cfg_index = 0;
        cfg_wdata = 0;
        m_ready = 0;
        cfg_bw = 1024;
        cfg_bh = 1024;
        cfg_heur = HEUR_SHORT;
        spilled = 0;
        empty_bin();
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        send_idle = 8;
        recv_idle = 54;

        // Directed: zero sizes, oversize, whole bin, refill
        queue_req(OP_INSERT, 0, 0);
        queue_req(OP_INSERT, 0, 5);
        queue_req(OP_INSERT, 5, 0);
        queue_req(OP_INSERT, 8191, 8191);
        queue_req(OP_INSERT, 100, 200);
        queue_req(OP_INSERT, 924, 1024);
        queue_req(OP_INSERT, 1, 1);
        queue_req(OP_RESET, 8191, 8191);
        queue_req(OP_INSERT, 1024, 1024);
        drain();

        // Bin beyond the largest size, heuristic code past the last one
        setup_bin(8191, 4096, 7);
        queue_req(OP_INSERT, 4096, 4096);
        queue_req(OP_INSERT, 1, 1);
        queue_req(OP_RESET, 0, 0);
        queue_req(OP_INSERT, 4095, 2048);
        queue_req(OP_INSERT, 1, 2048);
        drain();

        // Empty bin: nothing fits
        setup_bin(0, 1024, HEUR_AREA);
        queue_req(OP_INSERT, 1, 1);
        drain();

        // Random runs across all heuristics and idle patterns
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0, 1: begin send_idle = 8; recv_idle = 54; end
                2, 3: begin send_idle = 54; recv_idle = 8; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            if (ph == 5) begin
                bw = 4096;
                bh = 1;
            end else begin
                bw = $urandom_range(64, 1);
                bh = $urandom_range(64, 1);
            end
            setup_bin(bw, bh, ph == 5 ? HEUR_CONTACT : ph);
            random_run(12, bw, bh);
            drain();
        end

        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mrp_pkg.sv
rtl/mrp_score.sv
rtl/maxrects_rectangle_packer_core.sv
rtl/mrp_checker.sv
tb/maxrects_rectangle_packer_core_tb.sv
